// ===== hw/rtl/umfr_pkg.sv =====
// ----------------------------------------------------------------------------
// umfr_pkg: motor link frame receiver definitions
// Word types for the input and result channels, status codes and frame
// layout constants.
// ----------------------------------------------------------------------------
package umfr_pkg;

	localparam int FRAME_BYTES = 15;
	localparam logic [7:0] LENGTH_CODE = 8'h0A;

	// configuration register indexes
	localparam logic [1:0] REG_SYNC_BYTE     = 2'd0;
	localparam logic [1:0] REG_EXPECTED_ID   = 2'd1;
	localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

	// result status codes
	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_ACCEPT  = 3'd1;
	localparam logic [2:0] ST_BADSUM  = 3'd2;
	localparam logic [2:0] ST_HEADER  = 3'd3;
	localparam logic [2:0] ST_TIMEOUT = 3'd4;

	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	typedef struct packed {
		logic       action;
		logic [7:0] rx_byte;
	} umfr_in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [23:0] motor_speed;
		logic [7:0]  motor_temperature;
		logic [7:0]  fault_status;
		logic [39:0] spare_bytes;
		logic        link_error;
	} umfr_out_t;

endpackage

// ===== hw/rtl/uart_motor_frame_receiver_top.sv =====
// ----------------------------------------------------------------------------
// uart_motor_frame_receiver_top: motor link frame receiver
// Deframes received bytes into fixed 15-byte frames and latches motor data
// from frames with a good checksum; timer ticks drive a link timeout.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one word per received byte or timer tick
//   (action 0 = byte, 1 = tick). Every accepted word yields exactly one
//   result word on out_valid/out_ready, in the cycle after acceptance.
//   Throughput is one word per cycle while out_ready stays high: the whole
//   frame step (header checks, running 16-bit sum, checksum compare, tick
//   compare) is one pass of logic ahead of the result register.
//   The result word carries the status of that step and the latched motor
//   fields and link error as they stand after it.
//   When the consumer stalls, the pending result holds and in_ready drops
//   until it is taken; a new word is taken in the same cycle the pending one
//   leaves.
//   Reset clears the byte counter, running sum, tick counter, link error and
//   latched fields; the sync byte and expected id return to 0, the timeout
//   to 100 ticks. Configuration writes (cfg_we/cfg_index/cfg_wdata) are
//   registered and are meant for idle periods.
// ----------------------------------------------------------------------------
module uart_motor_frame_receiver_top
	import umfr_pkg::*;
#(
	parameter int TICK_COUNT_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  umfr_in_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output umfr_out_t  out_data
);

	localparam int CMP_BITS = (TICK_COUNT_BITS > 16) ? TICK_COUNT_BITS : 16;

	logic [7:0]  sync_byte_q;
	logic [7:0]  expected_id_q;
	logic [15:0] timeout_ticks_q;

	logic [7:0]  frame_q [FRAME_BYTES];
	logic [3:0]  byte_cnt_q;
	logic [15:0] sum_q;
	logic [TICK_COUNT_BITS-1:0] tick_cnt_q;
	logic        link_err_q;
	logic [23:0] speed_q;
	logic [7:0]  temp_q;
	logic [7:0]  fault_q;
	logic [39:0] spare_q;
	logic [2:0]  status_q;
	logic        out_valid_q;

	logic        accept;
	logic [3:0]  idx;
	logic [3:0]  cnt_inc;
	logic [7:0]  first_byte;
	logic [15:0] sum_upd;
	logic [TICK_COUNT_BITS-1:0] tick_inc;
	logic        tick_expired;

	logic [2:0]  status_nxt;
	logic [3:0]  byte_cnt_nxt;
	logic [TICK_COUNT_BITS-1:0] tick_cnt_nxt;
	logic        link_err_nxt;
	logic        latch;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	assign idx        = (byte_cnt_q >= 4'(FRAME_BYTES)) ? 4'd0 : byte_cnt_q;
	assign cnt_inc    = idx + 4'd1;
	assign first_byte = (idx == 4'd0) ? in_data.rx_byte : frame_q[0];
	assign sum_upd    = (idx == 4'd0) ? 16'd0 :
	                    (idx <= 4'd12) ? sum_q + {8'd0, in_data.rx_byte} : sum_q;

	assign tick_inc     = tick_cnt_q + 1'b1;
	assign tick_expired = CMP_BITS'(tick_inc) >= CMP_BITS'(timeout_ticks_q);

	always_comb begin
		status_nxt   = ST_IDLE;
		byte_cnt_nxt = byte_cnt_q;
		tick_cnt_nxt = tick_cnt_q;
		link_err_nxt = link_err_q;
		latch        = 1'b0;
		if (in_data.action == ACT_TICK) begin
			tick_cnt_nxt = tick_inc;
			if (tick_expired) begin
				tick_cnt_nxt = '0;
				byte_cnt_nxt = 4'd0;
				link_err_nxt = 1'b1;
				status_nxt   = ST_TIMEOUT;
			end
		end else begin
			byte_cnt_nxt = cnt_inc;
			// stored sync byte is rechecked on every byte
			if (first_byte != sync_byte_q) begin
				byte_cnt_nxt = 4'd0;
				status_nxt   = ST_HEADER;
			end else if (cnt_inc == 4'd2) begin
				if (in_data.rx_byte != expected_id_q) begin
					byte_cnt_nxt = 4'd0;
					status_nxt   = ST_HEADER;
				end
			end else if (cnt_inc == 4'd3) begin
				if (in_data.rx_byte != LENGTH_CODE) begin
					byte_cnt_nxt = 4'd0;
					status_nxt   = ST_HEADER;
				end
			end else if (cnt_inc == 4'(FRAME_BYTES)) begin
				byte_cnt_nxt = 4'd0;
				if ({frame_q[13], in_data.rx_byte} == sum_upd) begin
					latch        = 1'b1;
					link_err_nxt = 1'b0;
					tick_cnt_nxt = '0;
					status_nxt   = ST_ACCEPT;
				end else begin
					status_nxt   = ST_BADSUM;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_byte_q     <= 8'd0;
			expected_id_q   <= 8'd0;
			timeout_ticks_q <= 16'd100;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SYNC_BYTE:     sync_byte_q     <= cfg_wdata[7:0];
				REG_EXPECTED_ID:   expected_id_q   <= cfg_wdata[7:0];
				REG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// frame storage, no reset: each entry is written before it is read
	always_ff @(posedge clk) begin
		if (accept && in_data.action == ACT_BYTE) begin
			frame_q[idx] <= in_data.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q  <= 4'd0;
			sum_q       <= 16'd0;
			tick_cnt_q  <= '0;
			link_err_q  <= 1'b0;
			speed_q     <= 24'd0;
			temp_q      <= 8'd0;
			fault_q     <= 8'd0;
			spare_q     <= 40'd0;
			status_q    <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				byte_cnt_q <= byte_cnt_nxt;
				tick_cnt_q <= tick_cnt_nxt;
				link_err_q <= link_err_nxt;
				status_q   <= status_nxt;
				if (in_data.action == ACT_BYTE) begin
					sum_q <= sum_upd;
				end
				if (latch) begin
					speed_q <= {frame_q[3], frame_q[4], frame_q[5]};
					temp_q  <= frame_q[6];
					fault_q <= frame_q[7];
					spare_q <= {frame_q[8], frame_q[9], frame_q[10], frame_q[11], frame_q[12]};
				end
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid                  = out_valid_q;
	assign out_data.status            = status_q;
	assign out_data.motor_speed       = speed_q;
	assign out_data.motor_temperature = temp_q;
	assign out_data.fault_status      = fault_q;
	assign out_data.spare_bytes       = spare_q;
	assign out_data.link_error        = link_err_q;

endmodule

// ===== tb/uart_motor_frame_receiver_top_tb.sv =====
// ----------------------------------------------------------------------------
// uart_motor_frame_receiver_top_tb: self-checking bench for the frame receiver
// Drives bytes and ticks through the input channel, in most phases with random
// bursts and gaps, while in some phases the result side stalls on its own
// pattern. A frame tracker follows the deframing state, checksum, tick counter
// and latched motor fields, and every result word is checked against it in order.
// ----------------------------------------------------------------------------
module uart_motor_frame_receiver_top_tb;
	import umfr_pkg::*;

	localparam int LAST_SUMMED = 12;   // checksum covers bytes 1 through 12
	localparam int PHASE_WORDS = 112;
	localparam int RUN_LIMIT   = 2_000_000;

	typedef enum int {FLAW_NONE, FLAW_SUM, FLAW_SYNC, FLAW_ID, FLAW_LEN, FLAW_CUT} frame_flaw_e;
	typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_e;

	// Tracks the receiver state and holds the result words still to come.
	class link_frame_tracker;
		logic [7:0]  sync_byte     = 8'h00;
		logic [7:0]  expected_id   = 8'h00;
		logic [15:0] timeout_ticks = 16'd100;
		logic [7:0]  frame_buf [FRAME_BYTES] = '{default: 8'h00};
		int          byte_count    = 0;
		logic [15:0] running_sum   = '0;
		logic [15:0] idle_ticks    = '0;
		logic        link_err      = 1'b0;
		logic [23:0] speed_q       = '0;
		logic [7:0]  temp_q        = '0;
		logic [7:0]  fault_q       = '0;
		logic [39:0] spare_q       = '0;
		umfr_out_t   pending_results [$];
		int          failures      = 0;
		int          checked       = 0;
		int          status_seen [5] = '{default: 0};

		function void note_word(umfr_in_t w);
			umfr_out_t  r;
			logic [2:0] st;
			int         idx;
			st = ST_IDLE;
			if (w.action == ACT_TICK) begin
				idle_ticks = idle_ticks + 16'd1;
				if (idle_ticks >= timeout_ticks) begin
					idle_ticks = '0;
					byte_count = 0;
					link_err = 1'b1;
					st = ST_TIMEOUT;
				end
			end else begin
				idx = byte_count;
				frame_buf[idx] = w.rx_byte;
				if (idx == 0)
					running_sum = '0;
				else if (idx <= LAST_SUMMED)
					running_sum = running_sum + w.rx_byte;
				byte_count = idx + 1;
				// the stored first byte is checked on every byte
				if (frame_buf[0] != sync_byte) begin
					byte_count = 0;
					st = ST_HEADER;
				end else if (byte_count == 2) begin
					if (frame_buf[1] != expected_id) begin
						byte_count = 0;
						st = ST_HEADER;
					end
				end else if (byte_count == 3) begin
					if (frame_buf[2] != LENGTH_CODE) begin
						byte_count = 0;
						st = ST_HEADER;
					end
				end else if (byte_count == FRAME_BYTES) begin
					byte_count = 0;
					if ({frame_buf[13], frame_buf[14]} == running_sum) begin
						speed_q = {frame_buf[3], frame_buf[4], frame_buf[5]};
						temp_q = frame_buf[6];
						fault_q = frame_buf[7];
						spare_q = {frame_buf[8], frame_buf[9], frame_buf[10], frame_buf[11],
							frame_buf[12]};
						link_err = 1'b0;
						idle_ticks = '0;
						st = ST_ACCEPT;
					end else begin
						st = ST_BADSUM;
					end
				end
			end
			r.status = st;
			r.motor_speed = speed_q;
			r.motor_temperature = temp_q;
			r.fault_status = fault_q;
			r.spare_bytes = spare_q;
			r.link_error = link_err;
			pending_results.push_back(r);
		endfunction

		function void check_word(umfr_out_t got);
			umfr_out_t want;
			string     bad;
			if (pending_results.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("ERROR: result word with nothing pending: %h", got);
				return;
			end
			want = pending_results.pop_front();
			checked++;
			status_seen[want.status]++;
			bad = "";
			if (got.status !== want.status)                 bad = {bad, " status"};
			if (got.motor_speed !== want.motor_speed)       bad = {bad, " speed"};
			if (got.motor_temperature !== want.motor_temperature) bad = {bad, " temperature"};
			if (got.fault_status !== want.fault_status)     bad = {bad, " fault"};
			if (got.spare_bytes !== want.spare_bytes)       bad = {bad, " spare"};
			if (got.link_error !== want.link_error)         bad = {bad, " link_error"};
			if (bad != "") begin
				failures++;
				if (failures <= 10) begin
					$display("ERROR: word %0d mismatch on%s", checked, bad);
					$display("  expected st %0d spd %h tmp %h flt %h spr %h lnk %b",
						want.status, want.motor_speed, want.motor_temperature,
						want.fault_status, want.spare_bytes, want.link_error);
					$display("  actual   st %0d spd %h tmp %h flt %h spr %h lnk %b",
						got.status, got.motor_speed, got.motor_temperature,
						got.fault_status, got.spare_bytes, got.link_error);
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_SYNC_BYTE;
	logic [15:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	umfr_in_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	umfr_out_t   out_data;

	link_frame_tracker tracker = new;

	logic [7:0]  link_sync = 8'h00;
	logic [7:0]  link_id = 8'h00;
	bit          sender_gaps = 1'b0;
	int          burst_left = 0;
	int          items_sent = 0;
	int          settings_done = 0;
	stall_mode_e stall_mode = STALL_NONE;
	int          stall_phase = 0;

	uart_motor_frame_receiver_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		case (stall_mode)
			STALL_NONE: out_ready <= 1'b1;
			STALL_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
			default: begin
				stall_phase = (stall_phase + 1) % 11;
				out_ready <= (stall_phase < 6);
			end
		endcase
	end

	// accepted inputs are noted before results are checked
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				tracker.note_word(in_data);
			if (out_valid && out_ready)
				tracker.check_word(out_data);
		end
	end

	initial begin
		#(RUN_LIMIT);
		$display("ERROR: run did not finish in time");
		$display("FAIL uart_motor_frame_receiver_top");
		$finish;
	end

	function automatic umfr_in_t make_word(logic act, logic [7:0] b);
		umfr_in_t w;
		w.action = act;
		w.rx_byte = b;
		return w;
	endfunction

	task automatic send_word(input umfr_in_t w);
		if (sender_gaps) begin
			if (burst_left == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = $urandom_range(1, 12);
			end
			burst_left--;
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	// hold the sender until every pending result word has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic program_link(input logic [7:0] s, input logic [7:0] id,
		input logic [15:0] to);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= REG_SYNC_BYTE;
		cfg_wdata <= {8'($urandom), s};
		@(posedge clk);
		cfg_index <= REG_EXPECTED_ID;
		cfg_wdata <= {8'($urandom), id};
		@(posedge clk);
		cfg_index <= REG_TIMEOUT_TICKS;
		cfg_wdata <= to;
		@(posedge clk);
		cfg_we <= 1'b0;
		link_sync = s;
		link_id = id;
		tracker.sync_byte = s;
		tracker.expected_id = id;
		tracker.timeout_ticks = to;
		settings_done++;
	endtask

	// fill < 0 gives random data bytes
	task automatic send_frame(input frame_flaw_e flaw, input int fill, input int tick_pct);
		logic [7:0]  fr [FRAME_BYTES];
		logic [15:0] sum;
		int          stop_at;
		fr[0] = link_sync;
		fr[1] = link_id;
		fr[2] = LENGTH_CODE;
		for (int k = 3; k <= LAST_SUMMED; k++)
			fr[k] = (fill < 0) ? 8'($urandom) : 8'(fill);
		sum = '0;
		for (int k = 1; k <= LAST_SUMMED; k++)
			sum = sum + fr[k];
		fr[13] = sum[15:8];
		fr[14] = sum[7:0];
		stop_at = FRAME_BYTES;
		case (flaw)
			FLAW_SUM: fr[$urandom_range(13, 14)] ^= 8'($urandom_range(1, 255));
			FLAW_SYNC: begin
				fr[0] ^= 8'($urandom_range(1, 255));
				stop_at = $urandom_range(1, 3);
			end
			FLAW_ID: fr[1] ^= 8'($urandom_range(1, 255));
			FLAW_LEN: fr[2] ^= 8'($urandom_range(1, 255));
			FLAW_CUT: stop_at = $urandom_range(1, FRAME_BYTES - 1);
			default: ;
		endcase
		for (int k = 0; k < stop_at; k++) begin
			if ($urandom_range(0, 99) < tick_pct)
				send_word(make_word(ACT_TICK, 8'($urandom)));
			send_word(make_word(ACT_BYTE, fr[k]));
		end
	endtask

	initial begin
		int          pick;
		int          phase_end;
		frame_flaw_e flaw;
		int          fails;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, full-scale frame, each header reject, timeout
		send_word(make_word(ACT_TICK, 8'hFF));
		send_frame(FLAW_NONE, 8'hFF, 0);
		send_word(make_word(ACT_BYTE, 8'h01));
		send_word(make_word(ACT_BYTE, 8'h00));
		send_word(make_word(ACT_BYTE, 8'h01));
		send_word(make_word(ACT_BYTE, 8'h00));
		send_word(make_word(ACT_BYTE, 8'h00));
		send_word(make_word(ACT_BYTE, 8'h0B));
		program_link(8'h00, 8'h00, 16'd1);
		send_word(make_word(ACT_TICK, 8'h00));

		for (int p = 0; p < 5; p++) begin
			case (p)
				0: program_link(8'h5A, 8'hC3, 16'd20);
				1: program_link(8'hFF, 8'hFF, 16'd1);
				2: program_link(8'h00, 8'hFF, 16'd65535);
				3: program_link(8'hFF, 8'h00, 16'd5);
				default: program_link(8'($urandom), 8'($urandom),
					16'($urandom_range(2, 200)));
			endcase
			sender_gaps = (p != 2);
			stall_mode = stall_mode_e'(p % 3);
			phase_end = items_sent + PHASE_WORDS;
			while (items_sent < phase_end) begin
				pick = $urandom_range(0, 99);
				if (pick < 65) begin
					pick = $urandom_range(0, 99);
					if (pick < 55)      flaw = FLAW_NONE;
					else if (pick < 70) flaw = FLAW_SUM;
					else if (pick < 78) flaw = FLAW_SYNC;
					else if (pick < 86) flaw = FLAW_ID;
					else if (pick < 93) flaw = FLAW_LEN;
					else                flaw = FLAW_CUT;
					if ($urandom_range(0, 9) == 0)
						send_frame(flaw, $urandom_range(0, 1) ? 8'hFF : 8'h00, 4);
					else
						send_frame(flaw, -1, 4);
				end else if (pick < 80) begin
					repeat ($urandom_range(1, 6))
						send_word(make_word(ACT_TICK, 8'($urandom)));
				end else if (pick < 96) begin
					send_word(make_word(ACT_BYTE, 8'($urandom)));
				end else begin
					drain();
				end
			end
			// leave a frame partly received so the next sync setting lands mid-frame
			send_frame(FLAW_CUT, -1, 0);
		end

		drain();
		repeat (5) @(posedge clk);
		fails = tracker.failures + tracker.pending_results.size();
		$display("Covered %0d words over %0d register settings, %0d results checked",
			items_sent, settings_done, tracker.checked);
		$display("Accepted %0d, bad checksum %0d, header reject %0d, timeout %0d, errors %0d",
			tracker.status_seen[ST_ACCEPT], tracker.status_seen[ST_BADSUM],
			tracker.status_seen[ST_HEADER], tracker.status_seen[ST_TIMEOUT], fails);
		if (fails == 0)
			$display("PASS uart_motor_frame_receiver_top");
		else
			$display("FAIL uart_motor_frame_receiver_top");
		$finish;
	end

endmodule
